// ===== rtl/pem_pkg.sv =====
// ----------------------------------------------------------------------------
// pem_pkg
// Shared types and constants of the 3x3 Prewitt edge magnitude block.
// ----------------------------------------------------------------------------
package pem_pkg;

    // field widths
    localparam int PIXEL_W     = 32;
    localparam int GRAY_W      = 8;
    localparam int GRAY_SUM_W  = GRAY_W + 2;
    localparam int EDGE_W      = 8;
    localparam int OUT_COL_W   = 11;
    localparam int OUT_ROW_W   = 12;
    localparam int ROW_W       = 12;
    localparam int M_TDATA_W   = 32;

    // configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int WIDTH_REG_W = 12;
    localparam int HEIGHT_W    = 13;

    // image size limits and reset values
    localparam int DIM_MIN        = 3;
    localparam int HEIGHT_MAX     = 4096;
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;
    localparam int EDGE_MAX       = 255;

    // kernel arithmetic
    localparam int COL_SUM_W   = GRAY_W + 2;
    localparam int GRAD_W      = COL_SUM_W + 1;
    localparam int ABS_W       = COL_SUM_W;
    localparam int TOTAL_W     = ABS_W + 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // classified pixel word passed from front to back
    typedef struct packed {
        logic                 frame_end;
        logic                 emit;
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic [GRAY_W-1:0]    gray;
    } pem_tag_t;

    localparam int TAG_W = $bits(pem_tag_t);

endpackage

// ===== rtl/pem_front.sv =====
// ----------------------------------------------------------------------------
// pem_front
// Size registers, raster position counters, gray reduction and result
// classification of each incoming pixel word.
// ----------------------------------------------------------------------------
module pem_front
    import pem_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int CW        = 11
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,
    // classified word to the queue
    output logic                  tok_valid,
    input  logic                  tok_ready,
    output logic [CW-1:0]         tok_idx,
    output pem_tag_t              tok_tag
);

    // compare width for the column against the row length
    localparam int EW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;

    function automatic logic [EW-1:0] sat_width(input logic [WIDTH_REG_W-1:0] v);
        logic [EW-1:0] r;
        if (v < WIDTH_REG_W'(DIM_MIN)) begin
            r = EW'(DIM_MIN);
        end else if (EW'(v) > EW'(MAX_WIDTH)) begin
            r = EW'(MAX_WIDTH);
        end else begin
            r = EW'(v);
        end
        return r;
    endfunction

    function automatic logic [HEIGHT_W-1:0] sat_height(input logic [HEIGHT_W-1:0] v);
        logic [HEIGHT_W-1:0] r;
        if (v < HEIGHT_W'(DIM_MIN)) begin
            r = HEIGHT_W'(DIM_MIN);
        end else if (v > HEIGHT_W'(HEIGHT_MAX)) begin
            r = HEIGHT_W'(HEIGHT_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [EW-1:0]       width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;

    logic                  accept;
    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [EW-1:0]         col_wide;
    logic [HEIGHT_W-1:0]   row_wide;
    logic                  col_last, row_last;

    assign cfg_ready = 1'b1;
    assign s_tready  = tok_ready;
    assign tok_valid = s_tvalid;
    assign accept    = s_tvalid && tok_ready;

    // size registers, kept already clamped to their legal range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= sat_width(WIDTH_REG_W'(WIDTH_RESET));
            height_reg <= sat_height(HEIGHT_W'(HEIGHT_RESET));
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= sat_width(cfg_data[WIDTH_REG_W-1:0]);
                REG_IMAGE_HEIGHT: height_reg <= sat_height(cfg_data[HEIGHT_W-1:0]);
                default: ;
            endcase
        end
    end

    // gray level and classification of the current word
    always_comb begin
        gray_sum = GRAY_SUM_W'(s_tdata[7:0]) + GRAY_SUM_W'(s_tdata[15:8])
                 + GRAY_SUM_W'(s_tdata[23:16]) + GRAY_SUM_W'(s_tdata[31:24]);
        col_wide = EW'(col_reg);
        row_wide = HEIGHT_W'(row_reg);
        col_last = (col_wide + EW'(1)) >= width_reg;
        row_last = (row_wide + HEIGHT_W'(1)) >= height_reg;

        tok_idx           = col_reg;
        tok_tag.gray      = gray_sum[GRAY_SUM_W-1:2];
        tok_tag.out_col   = OUT_COL_W'(col_reg - CW'(2));
        tok_tag.out_row   = OUT_ROW_W'(row_reg - ROW_W'(2));
        tok_tag.emit      = (col_reg >= CW'(2)) && (row_reg >= ROW_W'(2));
        tok_tag.frame_end = (col_wide == width_reg - EW'(1))
                         && (row_wide == height_reg - HEIGHT_W'(1));
    end

    // raster position of the next pixel
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/pem_queue.sv =====
// ----------------------------------------------------------------------------
// pem_queue
// Short register queue between the front and the back of the block.
// ----------------------------------------------------------------------------
module pem_queue
    import pem_pkg::*;
#(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_pop,
    output logic [DATA_W-1:0] out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]     count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != NW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/pem_back.sv =====
// ----------------------------------------------------------------------------
// pem_back
// Line store, 3x3 window and kernel pipeline with the output register.
// ----------------------------------------------------------------------------
module pem_back
    import pem_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int CW        = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // classified words from the queue
    input  logic                 q_valid,
    output logic                 q_pop,
    input  logic [CW-1:0]        q_idx,
    input  pem_tag_t             q_tag,
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int LINE_W = 2 * GRAY_W;

    // line store entry: upper row in the high byte, middle row in the low byte
    logic [LINE_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] line_rd_reg;

    logic              adv;
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [CW-1:0]     s1_idx_reg;
    pem_tag_t          s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic [GRAY_W-1:0] win_reg [9];
    logic signed [GRAD_W-1:0] gv_reg, gh_reg;

    logic [GRAY_W-1:0]    top_g, mid_g;
    logic [COL_SUM_W-1:0] sum_top, sum_bot, sum_left, sum_right;
    logic [ABS_W-1:0]     abs_v, abs_h;
    logic [TOTAL_W-1:0]   total;
    logic [EDGE_W-1:0]    edge_val;

    logic                 m_valid_reg;
    logic [EDGE_W-1:0]    m_edge_reg;
    logic [OUT_COL_W-1:0] m_col_reg;
    logic [OUT_ROW_W-1:0] m_row_reg;
    logic                 m_last_reg;

    // whole pipeline moves when the output register can take a word
    assign adv   = !m_valid_reg || m_tready;
    assign q_pop = adv && q_valid;
    assign top_g = line_rd_reg[LINE_W-1:GRAY_W];
    assign mid_g = line_rd_reg[GRAY_W-1:0];

    // line store: read for the popped word, write back for the word in stage 1
    always_ff @(posedge aclk) begin
        if (adv && s1_valid_reg) begin
            line_mem[s1_idx_reg] <= {mid_g, s1_tag_reg.gray};
        end
        if (adv) begin
            line_rd_reg <= line_mem[q_idx];
        end
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage payloads and window shift
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_idx_reg <= q_idx;
            s1_tag_reg <= q_tag;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
            if (s1_valid_reg) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[r*3 + 0] <= win_reg[r*3 + 1];
                    win_reg[r*3 + 1] <= win_reg[r*3 + 2];
                end
                win_reg[2] <= top_g;
                win_reg[5] <= mid_g;
                win_reg[8] <= s1_tag_reg.gray;
            end
        end
    end

    // vertical and horizontal gradients of the window
    always_comb begin
        sum_top   = COL_SUM_W'(win_reg[0]) + COL_SUM_W'(win_reg[1]) + COL_SUM_W'(win_reg[2]);
        sum_bot   = COL_SUM_W'(win_reg[6]) + COL_SUM_W'(win_reg[7]) + COL_SUM_W'(win_reg[8]);
        sum_left  = COL_SUM_W'(win_reg[0]) + COL_SUM_W'(win_reg[3]) + COL_SUM_W'(win_reg[6]);
        sum_right = COL_SUM_W'(win_reg[2]) + COL_SUM_W'(win_reg[5]) + COL_SUM_W'(win_reg[8]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            gv_reg <= $signed({1'b0, sum_top})  - $signed({1'b0, sum_bot});
            gh_reg <= $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
        end
    end

    // four absolute responses are twice the two gradient magnitudes
    always_comb begin
        abs_v    = gv_reg[GRAD_W-1] ? ABS_W'(-gv_reg) : ABS_W'(gv_reg);
        abs_h    = gh_reg[GRAD_W-1] ? ABS_W'(-gh_reg) : ABS_W'(gh_reg);
        total    = (TOTAL_W'(abs_v) + TOTAL_W'(abs_h)) << 1;
        edge_val = (total > TOTAL_W'(EDGE_MAX)) ? EDGE_W'(EDGE_MAX) : total[EDGE_W-1:0];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= s3_valid_reg && s3_tag_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_edge_reg <= edge_val;
            m_col_reg  <= s3_tag_reg.out_col;
            m_row_reg  <= s3_tag_reg.out_row;
            m_last_reg <= s3_tag_reg.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = M_TDATA_W'({m_row_reg, m_col_reg, m_edge_reg});

endmodule

// ===== rtl/prewitt_edge_magnitude_3x3.sv =====
// ----------------------------------------------------------------------------
// prewitt_edge_magnitude_3x3
// Streaming 3x3 Prewitt edge magnitude over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one 32-bit pixel per clock while s_tready is high, in raster order,
// reduces it to a gray level (sum of the four bytes over four) and, once
// the pixel completes a 3x3 window (column and row both at least 2), emits
// one byte 2*|Gv| + 2*|Gh| saturated at 255 with the window's top-left
// column and row; tlast marks the pixel at the last column of the last row.
// Sustained rate is one pixel per cycle while the output is not stalled,
// set by the line store, which does one read and one write per cycle. A
// four-word queue separates the input side from the kernel pipeline, so
// input is taken while a result waits. The image size must be written
// through the cfg port only while the block is idle, which the block does
// not enforce; it is clamped to 3..MAX_WIDTH columns and 3..4096 rows;
// the line store needs no clearing after reset.
// ----------------------------------------------------------------------------
module prewitt_edge_magnitude_3x3
    import pem_pkg::*;
#(
    parameter int MAX_WIDTH   = 2048,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,   // pixel[31:0]
    // edge results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // edge_value[7:0], out_col[18:8],
                                             // out_row[30:19], zero[31]
    output logic                  m_tlast    // frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = CW + TAG_W;

    logic          tok_valid, tok_ready;
    logic [CW-1:0] tok_idx;
    pem_tag_t      tok_tag;
    logic          q_valid, q_pop;
    logic [QW-1:0] q_data;
    logic [CW-1:0] q_idx;
    pem_tag_t      q_tag;

    // front: size registers, position counters, classification
    pem_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_idx   (tok_idx),
        .tok_tag   (tok_tag)
    );

    // queue between front and back
    pem_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tok_valid),
        .in_ready  (tok_ready),
        .in_data   ({tok_idx, tok_tag}),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_data  (q_data)
    );

    assign q_idx = q_data[QW-1:TAG_W];
    assign q_tag = pem_tag_t'(q_data[TAG_W-1:0]);

    // back: line store, window, kernels, output register
    pem_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_idx    (q_idx),
        .q_tag    (q_tag),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef ASSERT_OFF
    // no result is shown in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled output freezes the back, so nothing leaves the queue
    a_stall_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !q_pop)
        else $error("queue popped while output stalled");

    // input back-pressure only when the queue holds words
    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_valid)
        else $error("input stalled with empty queue");

    // the last result of a frame always has a full window behind it
    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_valid && tok_ready && tok_tag.frame_end) |-> tok_tag.emit)
        else $error("frame end on a pixel without a complete window");
`endif

endmodule
